@@ rtl/wbi_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and address-math helpers for the WLAN bit interleaver.
package wbi_pkg;

   // Widths of the address datapath (symbols hold at most 648 bits).
   localparam int POS_W      = 10;  // bit position / interleaved address
   localparam int EXT_W      = 11;  // position plus symbol length
   localparam int COL_W      = 5;   // column index, up to 17
   localparam int ROW_W      = 6;   // row index, up to 35
   localparam int RECIP_W    = 13;  // column reciprocal
   localparam int RECIP_SH   = 16;  // reciprocal scale, 2^16
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BITS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM = 2'd2;

   // Channel layout codes
   localparam logic [1:0] LAYOUT_LEGACY = 2'd0;
   localparam logic [1:0] LAYOUT_HT20   = 2'd1;
   localparam logic [1:0] LAYOUT_HT40   = 2'd2;

   // ceil(2^16 / d), exact for dividends below 1024 (d = columns) or 2048 (d = 3)
   localparam logic [RECIP_W-1:0] RECIP_16 = 13'd4096;
   localparam logic [RECIP_W-1:0] RECIP_13 = 13'd5042;
   localparam logic [RECIP_W-1:0] RECIP_18 = 13'd3641;
   localparam logic [15:0]        RECIP_3  = 16'd21846;

   typedef struct packed {
      logic in_bit;
   } req_payload_type;

   typedef struct packed {
      logic out_bit;
      logic out_valid;
      logic symbol_end;
   } rsp_payload_type;

   // Controller to datapath: one strobe per sequencer step
   typedef struct packed {
      logic accept;
      logic div_en;
      logic col_en;
      logic row_en;
      logic grp_en;
      logic join_en;
      logic rot_en;
      logic commit;
   } wbi_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rsp_free;
   } wbi_status_type;

   // Reserved layout code falls back to legacy
   function automatic logic [1:0] eff_layout(input logic [1:0] lay);
      logic [1:0] r;
      case (lay)
         LAYOUT_HT20: r = LAYOUT_HT20;
         LAYOUT_HT40: r = LAYOUT_HT40;
         default:     r = LAYOUT_LEGACY;
      endcase
      return r;
   endfunction

   // 0 reads as 1, 7 reads as 6
   function automatic logic [2:0] eff_bits(input logic [2:0] bps);
      logic [2:0] r;
      case (bps)
         3'd0:    r = 3'd1;
         3'd7:    r = 3'd6;
         default: r = bps;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] group_size(input logic [2:0] nb);
      logic [1:0] half;
      half = nb[2:1];
      return (half == 2'd0) ? 2'd1 : half;
   endfunction

   function automatic logic [COL_W-1:0] num_cols(input logic [1:0] lay);
      logic [COL_W-1:0] r;
      case (lay)
         LAYOUT_HT20: r = 5'd13;
         LAYOUT_HT40: r = 5'd18;
         default:     r = 5'd16;
      endcase
      return r;
   endfunction

   function automatic logic [RECIP_W-1:0] col_recip(input logic [1:0] lay);
      logic [RECIP_W-1:0] r;
      case (lay)
         LAYOUT_HT20: r = RECIP_13;
         LAYOUT_HT40: r = RECIP_18;
         default:     r = RECIP_16;
      endcase
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] num_rows(input logic [1:0] lay, input logic [2:0] nb);
      logic [ROW_W-1:0] k;
      case (lay)
         LAYOUT_HT20: k = 6'd4;
         LAYOUT_HT40: k = 6'd6;
         default:     k = 6'd3;
      endcase
      return k * ROW_W'(nb);
   endfunction

   // Full symbol length: carriers times bits per carrier
   function automatic logic [POS_W-1:0] sym_bits(input logic [1:0] lay, input logic [2:0] nb);
      logic [POS_W-1:0] nsd;
      case (lay)
         LAYOUT_HT20: nsd = 10'd52;
         LAYOUT_HT40: nsd = 10'd108;
         default:     nsd = 10'd48;
      endcase
      return nsd * POS_W'(nb);
   endfunction

   // Frequency rotation; jst*nrot stays below the carrier count, so the
   // modulo by the symbol length reduces to a plain product with nb.
   function automatic logic [POS_W-1:0] rot_amount(input logic [1:0] lay,
                                                   input logic [2:0] nb,
                                                   input logic [1:0] iss);
      logic [POS_W-1:0] base;
      base = '0;
      case (lay)
         LAYOUT_HT20: begin
            case (iss)
               2'd1:    base = 10'd22;
               2'd2:    base = 10'd11;
               2'd3:    base = 10'd33;
               default: base = 10'd0;
            endcase
         end
         LAYOUT_HT40: begin
            case (iss)
               2'd1:    base = 10'd58;
               2'd2:    base = 10'd29;
               2'd3:    base = 10'd87;
               default: base = 10'd0;
            endcase
         end
         default: base = 10'd0;
      endcase
      return base * POS_W'(nb);
   endfunction

   // x / s for s in 1..3, by shift or reciprocal multiply
   function automatic logic [EXT_W-1:0] div_group(input logic [EXT_W-1:0] x,
                                                  input logic [1:0] s);
      logic [EXT_W+15:0] p;
      logic [EXT_W-1:0]  r;
      p = (EXT_W+16)'(x) * (EXT_W+16)'(RECIP_3);
      case (s)
         2'd3:    r = p[EXT_W+15:16];
         2'd2:    r = x >> 1;
         default: r = x;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/wbi_chan_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload per transfer.
interface wbi_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/wbi_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer FSM: steps one bit through the address datapath.
module wbi_ctrl
   import wbi_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  wbi_status_type status,
   output wbi_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DIV    = 8'b0000_0010,
      ST_COL    = 8'b0000_0100,
      ST_ROW    = 8'b0000_1000,
      ST_GRP    = 8'b0001_0000,
      ST_JOIN   = 8'b0010_0000,
      ST_ROT    = 8'b0100_0000,
      ST_COMMIT = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      req_ready   = (state_ff == ST_IDLE) & ~reset;
      cmd.accept  = req_ready & req_valid;
      cmd.div_en  = (state_ff == ST_DIV);
      cmd.col_en  = (state_ff == ST_COL);
      cmd.row_en  = (state_ff == ST_ROW);
      cmd.grp_en  = (state_ff == ST_GRP);
      cmd.join_en = (state_ff == ST_JOIN);
      cmd.rot_en  = (state_ff == ST_ROT);
      cmd.commit  = (state_ff == ST_COMMIT) & status.rsp_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) state_in = ST_DIV;
         end
         ST_DIV:  state_in = ST_COL;
         ST_COL:  state_in = ST_ROW;
         ST_ROW:  state_in = ST_GRP;
         ST_GRP:  state_in = ST_JOIN;
         ST_JOIN: state_in = ST_ROT;
         ST_ROT:  state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/wbi_datapath.sv @@
`timescale 1ns / 1ps
// Config registers, interleaved-address arithmetic, ping-pong bank memory, result register.
module wbi_datapath
   import wbi_pkg::*;
#(
   parameter int MAX_SYMBOL_BITS = 648
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_payload_type       req_payload,
   input  wbi_cmd_type           cmd,
   output wbi_status_type        status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_payload
);

   localparam int AW = $clog2(MAX_SYMBOL_BITS);
   localparam logic [POS_W-1:0] MAX_LEN = POS_W'(MAX_SYMBOL_BITS);

   // configuration
   logic [1:0] layout_ff;
   logic [2:0] bps_ff;
   logic [1:0] iss_ff;

   logic [1:0]         lay;
   logic [2:0]         nb;
   logic [1:0]         grp_s;
   logic [COL_W-1:0]   ncol;
   logic [ROW_W-1:0]   nrow;
   logic [POS_W-1:0]   n_sym;
   logic [POS_W-1:0]   len;
   logic [POS_W-1:0]   rot;

   // symbol position state
   logic [POS_W-1:0] pos_ff;
   logic             wbank_ff;
   logic             primed_ff;
   logic [POS_W-1:0] q_c;
   logic             last_c;

   // per-item registers
   logic [POS_W-1:0] q_ff;
   logic             bank_ff;
   logic             in_bit_ff;
   logic             last_ff;
   logic             res_primed_ff;
   logic             rd_bit_ff;
   logic [ROW_W-1:0] quot_ff;
   logic [COL_W-1:0] col_ff;
   logic [POS_W-1:0] i_ff;
   logic [EXT_W-1:0] x_ff;
   logic [POS_W-1:0] is_ff;
   logic [EXT_W-1:0] xs_ff;
   logic [POS_W-1:0] j_ff;
   logic [POS_W-1:0] addr_ff;

   logic [POS_W+RECIP_W-1:0] qprod;
   logic [POS_W-1:0]         colprod;
   logic [POS_W-1:0]         col_full;
   logic [POS_W-1:0]         i_c;
   logic [EXT_W-1:0]         is_full;
   logic [EXT_W-1:0]         rem_c;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   logic bank_mem [2][MAX_SYMBOL_BITS];

   always_comb begin
      lay   = eff_layout(layout_ff);
      nb    = eff_bits(bps_ff);
      grp_s = group_size(nb);
      ncol  = num_cols(lay);
      nrow  = num_rows(lay, nb);
      n_sym = sym_bits(lay, nb);
      len   = (n_sym > MAX_LEN) ? MAX_LEN : n_sym;
      rot   = rot_amount(lay, nb, iss_ff);
      // a stale position past the end stands for the last position
      q_c    = (pos_ff < len) ? pos_ff : len - 1'b1;
      last_c = (q_c == len - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_LEGACY;
         bps_ff    <= 3'd1;
         iss_ff    <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LAYOUT: layout_ff <= csr_wdata[1:0];
            CSR_BITS:   bps_ff    <= csr_wdata;
            CSR_STREAM: iss_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         wbank_ff  <= 1'b0;
         primed_ff <= 1'b0;
      end else if (cmd.accept) begin
         if (last_c) begin
            pos_ff    <= '0;
            wbank_ff  <= ~wbank_ff;
            primed_ff <= 1'b1;
         end else begin
            pos_ff <= q_c + 1'b1;
         end
      end
   end

   // Address arithmetic:
   //   i = nrow*(q mod ncol) + q div ncol ; (ncol*i) div n equals q mod ncol
   //   j = s*(i div s) + (i + n - col) mod s ; addr = (j - rot) mod n
   always_comb begin
      qprod    = (POS_W+RECIP_W)'(q_ff) * (POS_W+RECIP_W)'(col_recip(lay));
      colprod  = POS_W'(quot_ff) * POS_W'(ncol);
      col_full = q_ff - colprod;
      i_c      = POS_W'(nrow) * POS_W'(col_ff) + POS_W'(quot_ff);
      is_full  = div_group(EXT_W'(i_ff), grp_s);
      rem_c    = x_ff - xs_ff * EXT_W'(grp_s);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         q_ff          <= q_c;
         bank_ff       <= wbank_ff;
         in_bit_ff     <= req_payload.in_bit;
         last_ff       <= last_c;
         res_primed_ff <= primed_ff;
      end
      if (cmd.div_en) begin
         quot_ff <= qprod[RECIP_SH+ROW_W-1:RECIP_SH];
      end
      if (cmd.col_en) begin
         col_ff <= col_full[COL_W-1:0];
      end
      if (cmd.row_en) begin
         i_ff <= i_c;
         x_ff <= EXT_W'(i_c) + EXT_W'(n_sym) - EXT_W'(col_ff);
      end
      if (cmd.grp_en) begin
         is_ff <= is_full[POS_W-1:0];
         xs_ff <= div_group(x_ff, grp_s);
      end
      if (cmd.join_en) begin
         j_ff <= is_ff * POS_W'(grp_s) + rem_c[POS_W-1:0];
      end
      if (cmd.rot_en) begin
         addr_ff <= (j_ff >= rot) ? (j_ff - rot) : (j_ff + n_sym - rot);
      end
   end

   // Previous symbol is read at accept; this symbol is written at commit.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_bit_ff <= bank_mem[~wbank_ff][q_c[AW-1:0]];
      end
      if (cmd.commit && (addr_ff < MAX_LEN)) begin
         bank_mem[bank_ff][addr_ff[AW-1:0]] <= in_bit_ff;
      end
   end

   assign status.rsp_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_payload_ff.out_bit    <= res_primed_ff & rd_bit_ff;
         rsp_payload_ff.out_valid  <= res_primed_ff;
         rsp_payload_ff.symbol_end <= last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_col_range : assert property (@(posedge clock) disable iff (reset)
      cmd.row_en |-> (col_ff < ncol))
      else $error("column index out of range");

   a_rem_range : assert property (@(posedge clock) disable iff (reset)
      cmd.join_en |-> (rem_c < EXT_W'(grp_s)))
      else $error("group remainder not below group size");

   a_j_range : assert property (@(posedge clock) disable iff (reset)
      cmd.rot_en |-> (j_ff < n_sym))
      else $error("permuted index beyond symbol length");

   a_addr_range : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (addr_ff < n_sym))
      else $error("interleaved address beyond symbol length");

endmodule

@@ rtl/wlan_bit_interleaver_unit.sv @@
`timescale 1ns / 1ps
// Top level of the WLAN OFDM bit interleaver for one spatial stream.
//
// Usage:
//   req_ch  : one coded bit per transfer (payload.in_bit), natural order.
//   rsp_ch  : one result per input transfer: out_bit is the bit of the previous
//             symbol at the same position in sequential order, out_valid is set
//             once a whole symbol is buffered, symbol_end flags a symbol's last bit.
//   csr_*   : write-only registers, index 0 layout (legacy / HT20 / HT40),
//             1 bits per subcarrier, 2 stream index. Write only while idle.
// Timing:
//   A bit is accepted, then a six-step address sequencer (divide, column, row,
//   group, join, rotate) works it out, then a commit cycle writes the bank and
//   loads the result register. A new bit is accepted only once the commit is
//   done and the sequencer is back in idle.
// Reset:
//   Synchronous. Clears position, bank select and primed flag, loads register
//   defaults; the bank memory itself is not cleared.
// Backpressure:
//   The result register holds a finished bit while the receiver stalls, and the
//   next bit is still taken and computed; it waits in the commit step until the
//   result register frees up.
module wlan_bit_interleaver_unit
   import wbi_pkg::*;
#(
   parameter int MAX_SYMBOL_BITS = 648
) (
   input  logic                  clock,
   input  logic                  reset,
   wbi_chan_if.sink              req_ch,
   wbi_chan_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   wbi_cmd_type     cmd;
   wbi_status_type  status;
   logic            ctrl_ready;
   logic            dp_rsp_valid;
   rsp_payload_type dp_rsp_payload;
   req_payload_type req_payload;

   assign req_payload.in_bit = req_ch.payload.in_bit;
   assign req_ch.ready       = ctrl_ready;

   wbi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wbi_datapath #(
      .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (dp_rsp_valid),
      .rsp_payload (dp_rsp_payload)
   );

   // result transfer
   assign rsp_ch.valid              = dp_rsp_valid;
   assign rsp_ch.payload.out_bit    = dp_rsp_payload.out_bit;
   assign rsp_ch.payload.out_valid  = dp_rsp_payload.out_valid;
   assign rsp_ch.payload.symbol_end = dp_rsp_payload.symbol_end;

endmodule
